[src/fit_policy_block_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Fit-policy block allocator: assertion macros
// Shared shorthand for the concurrent checks on the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPBA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpba: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpba: next-cycle check failed");

`endif

[src/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Field widths, policy codes, register selects and the structs that run
// between the allocator's top level and its cells.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int DEF_NUM_BLOCKS = 16;
	localparam int DEF_SIZE_BITS  = 16;

	localparam int AMOUNT_W   = 16;
	localparam int LOAD_IDX_W = 4;
	localparam int CHOSEN_W   = 4;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 5;
	localparam int PADDR_W    = 3;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_FIRST;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	// Register select is the word address bit of paddr.
	localparam logic REG_FIT_MODE    = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// Control part of the search token that walks along the cells.
	typedef struct packed {
		logic valid;
		logic found;
	} tok_ctl_t;

	// Write-back issued once a search has finished and its result is taken.
	typedef struct packed {
		logic apply;
		logic set_taken;
		logic sub_cap;
	} commit_t;

endpackage

[src/fpba_regs.sv]
// ----------------------------------------------------------------------------
// Fit-policy block allocator configuration registers
// APB-style write and read of the policy and block-count registers.
// ----------------------------------------------------------------------------
module fpba_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fpba_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic [fpba_pkg::MODE_W-1:0]    fit_mode,
	output logic [fpba_pkg::COUNT_W-1:0]   block_count
);
	import fpba_pkg::*;

	logic                wr_en;
	logic [MODE_W-1:0]   fit_mode_q;
	logic [COUNT_W-1:0]  block_count_q;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_RESET;
			block_count_q <= COUNT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FIT_MODE:    fit_mode_q    <= pwdata[MODE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIT_MODE:    prdata = 32'(fit_mode_q);
			REG_BLOCK_COUNT: prdata = 32'(block_count_q);
			default:         prdata = '0;
		endcase
	end

	assign fit_mode    = fit_mode_q;
	assign block_count = block_count_q;

endmodule

[src/fpba_cell.sv]
// ----------------------------------------------------------------------------
// Fit-policy block allocator cell
// Holds one block's capacity and taken mark, and updates the passing search
// token according to the active policy before handing it to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell #(
	parameter int IDX       = 0,
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = fpba_pkg::DEF_SIZE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fpba_pkg::MODE_W-1:0]     fit_mode,
	input  logic [fpba_pkg::COUNT_W-1:0]    block_count,
	input  logic                            load_en,
	input  logic [fpba_pkg::LOAD_IDX_W-1:0] load_index,
	input  logic [SIZE_BITS-1:0]            load_cap,
	input  fpba_pkg::commit_t               cmt,
	input  logic [IDX_W-1:0]                cmt_idx,
	input  logic [fpba_pkg::AMOUNT_W-1:0]   cmt_amount,
	input  fpba_pkg::tok_ctl_t              in_ctl,
	input  logic [fpba_pkg::AMOUNT_W-1:0]   in_amount,
	input  logic [IDX_W-1:0]                in_pick,
	input  logic [SIZE_BITS-1:0]            in_pcap,
	output fpba_pkg::tok_ctl_t              out_ctl,
	output logic [fpba_pkg::AMOUNT_W-1:0]   out_amount,
	output logic [IDX_W-1:0]                out_pick,
	output logic [SIZE_BITS-1:0]            out_pcap
);
	import fpba_pkg::*;

	localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	logic [SIZE_BITS-1:0] cap_q;
	logic                 taken_q;
	tok_ctl_t             ctl_q;
	logic [AMOUNT_W-1:0]  amount_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] pcap_q;

	logic                 in_use;
	logic                 fits;
	logic                 load_hit;
	logic                 cmt_hit;
	tok_ctl_t             nxt_ctl;
	logic [IDX_W-1:0]     nxt_pick;
	logic [SIZE_BITS-1:0] nxt_pcap;

	assign in_use   = 32'(IDX) < 32'(block_count);
	assign fits     = CMP_W'(cap_q) >= CMP_W'(in_amount);
	assign load_hit = load_en && (32'(load_index) == 32'(IDX));
	assign cmt_hit  = cmt.apply && (32'(cmt_idx) == 32'(IDX));

	always_comb begin
		nxt_ctl  = in_ctl;
		nxt_pick = in_pick;
		nxt_pcap = in_pcap;
		if (in_ctl.valid && in_use) begin
			unique case (fit_mode)
				MODE_FIRST: begin
					if (!in_ctl.found && !taken_q && fits) begin
						nxt_ctl.found = 1'b1;
						nxt_pick      = IDX_W'(IDX);
						nxt_pcap      = cap_q;
					end
				end
				MODE_BEST: begin
					if (fits && (!in_ctl.found || cap_q < in_pcap)) begin
						nxt_ctl.found = 1'b1;
						nxt_pick      = IDX_W'(IDX);
						nxt_pcap      = cap_q;
					end
				end
				MODE_WORST: begin
					// Largest free block; the size check is made at the end.
					if (!taken_q && (!in_ctl.found || cap_q > in_pcap)) begin
						nxt_ctl.found = 1'b1;
						nxt_pick      = IDX_W'(IDX);
						nxt_pcap      = cap_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
			ctl_q   <= '0;
		end else begin
			ctl_q <= nxt_ctl;
			if (load_hit) begin
				taken_q <= 1'b0;
			end else if (cmt_hit && cmt.set_taken) begin
				taken_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		amount_q <= in_amount;
		pick_q   <= nxt_pick;
		pcap_q   <= nxt_pcap;
		if (load_hit) begin
			cap_q <= load_cap;
		end else if (cmt_hit && cmt.sub_cap) begin
			cap_q <= SIZE_BITS'(CMP_W'(cap_q) - CMP_W'(cmt_amount));
		end
	end

	assign out_ctl    = ctl_q;
	assign out_amount = amount_q;
	assign out_pick   = pick_q;
	assign out_pcap   = pcap_q;

endmodule

[src/fit_policy_block_allocator.sv]
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Table of memory blocks searched by first, best or worst fit.
// ----------------------------------------------------------------------------
// The allocator keeps NUM_BLOCKS blocks, each with a capacity and a taken
// mark, in a row of cells. A load item (s_tuser low) writes one block's
// capacity and clears its taken mark; it gives no result, and the next
// item may follow at once. A request item (s_tuser high) sends a search
// token down the row, one cell per clock, so that every block in use is
// examined in turn under the policy held in the fit_mode register. The
// result leaves as one item on the master side, and the chosen block is
// updated when that result enters the output register. A request therefore
// holds s_tready low from acceptance until its result enters the output
// register, which waits while a held result is stalled on m_tready. Only
// the first block_count cells take part in a search; a count beyond
// NUM_BLOCKS counts as the whole row and a count of zero grants nothing.
// Loads to an index beyond the table are dropped. The user must write
// configuration only while no request is in flight; the block itself
// does not enforce this.
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
	parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // [3:0] load_index, [19:4] amount
	input  logic                          s_tuser,  // [0] op
	// Master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // [3:0] chosen_block
	output logic                          m_tuser,  // [0] granted
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpba_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import fpba_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	logic [MODE_W-1:0]     fit_mode;
	logic [COUNT_W-1:0]    block_count;

	logic                  in_acc;
	logic                  req_acc;
	logic                  load_en;
	logic [LOAD_IDX_W-1:0] in_load_index;
	logic [AMOUNT_W-1:0]   in_amount;

	// Search token at the input of each cell and after the last one.
	tok_ctl_t              chain_ctl    [NUM_BLOCKS+1];
	logic [AMOUNT_W-1:0]   chain_amount [NUM_BLOCKS+1];
	logic [IDX_W-1:0]      chain_pick   [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0]  chain_pcap   [NUM_BLOCKS+1];

	// Finished search waiting for the output register.
	logic                  busy_q;
	logic                  fin_valid_q;
	logic                  fin_found_q;
	logic [IDX_W-1:0]      fin_pick_q;
	logic [SIZE_BITS-1:0]  fin_pcap_q;
	logic [AMOUNT_W-1:0]   fin_amount_q;

	logic                  fin_grant;
	logic                  do_commit;
	commit_t               cmt;

	logic                  m_tvalid_q;
	logic                  granted_q;
	logic [CHOSEN_W-1:0]   chosen_q;

	fpba_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.fit_mode    (fit_mode),
		.block_count (block_count)
	);

	assign pready = 1'b1;

	assign s_tready      = !busy_q;
	assign in_acc        = s_tvalid && s_tready;
	assign req_acc       = in_acc && s_tuser;
	assign load_en       = in_acc && !s_tuser;
	assign in_load_index = s_tdata[LOAD_IDX_W-1:0];
	assign in_amount     = s_tdata[LOAD_IDX_W +: AMOUNT_W];

	// A new request enters the first cell with no candidate yet.
	assign chain_ctl[0]    = '{valid: req_acc, found: 1'b0};
	assign chain_amount[0] = in_amount;
	assign chain_pick[0]   = '0;
	assign chain_pcap[0]   = '0;

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fpba_cell #(
			.IDX       (g),
			.IDX_W     (IDX_W),
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.fit_mode    (fit_mode),
			.block_count (block_count),
			.load_en     (load_en),
			.load_index  (in_load_index),
			.load_cap    (SIZE_BITS'(in_amount)),
			.cmt         (cmt),
			.cmt_idx     (fin_pick_q),
			.cmt_amount  (fin_amount_q),
			.in_ctl      (chain_ctl[g]),
			.in_amount   (chain_amount[g]),
			.in_pick     (chain_pick[g]),
			.in_pcap     (chain_pcap[g]),
			.out_ctl     (chain_ctl[g+1]),
			.out_amount  (chain_amount[g+1]),
			.out_pick    (chain_pick[g+1]),
			.out_pcap    (chain_pcap[g+1])
		);
	end

	// Worst fit picks the largest free block first and only grants it when
	// it is large enough; the other policies only ever mark fitting blocks.
	assign fin_grant = fin_found_q &&
		((fit_mode != MODE_WORST) || (CMP_W'(fin_pcap_q) >= CMP_W'(fin_amount_q)));

	// The result moves into the output register once that register is free,
	// and the chosen block is updated in the same cycle.
	assign do_commit = fin_valid_q && (!m_tvalid_q || m_tready);

	assign cmt.apply     = do_commit && fin_grant;
	assign cmt.set_taken = fit_mode != MODE_BEST;
	assign cmt.sub_cap   = fit_mode == MODE_BEST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (req_acc) begin
				busy_q <= 1'b1;
			end else if (do_commit) begin
				busy_q <= 1'b0;
			end

			if (chain_ctl[NUM_BLOCKS].valid) begin
				fin_valid_q <= 1'b1;
			end else if (do_commit) begin
				fin_valid_q <= 1'b0;
			end

			if (do_commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_ctl[NUM_BLOCKS].valid) begin
			fin_found_q  <= chain_ctl[NUM_BLOCKS].found;
			fin_pick_q   <= chain_pick[NUM_BLOCKS];
			fin_pcap_q   <= chain_pcap[NUM_BLOCKS];
			fin_amount_q <= chain_amount[NUM_BLOCKS];
		end
		if (do_commit) begin
			granted_q <= fin_grant;
			chosen_q  <= fin_grant ? CHOSEN_W'(fin_pick_q) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = granted_q;
	assign m_tdata  = 8'(chosen_q);

endmodule

[src/fpba_checker.sv]
// ----------------------------------------------------------------------------
// Fit-policy block allocator port checker
// Watches the allocator's stream ports and flags handshake or result slips.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_defines.svh"

module fpba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,  // [0] op
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,  // [3:0] chosen_block
	input logic        m_tuser   // [0] granted
);

	// A refused request reports block zero and nothing in the padding.
	`FPBA_ASSERT_IMPL(a_no_grant_zero, m_tvalid && !m_tuser, m_tdata == 8'd0)

	// A request keeps the slave side closed while its search runs.
	`FPBA_ASSERT_NEXT(a_req_blocks, s_tvalid && s_tready && s_tuser, !s_tready)

	// A load completes in its own cycle and leaves the slave side open.
	`FPBA_ASSERT_NEXT(a_load_open, s_tvalid && s_tready && !s_tuser, s_tready)

	// A stalled result is held unchanged.
	`FPBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/tb_fit_policy_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator testbench
// Loads a table of blocks, then sends allocation requests under first, best
// and worst fit. Every granted or refused result is checked against a
// prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator;

	import fpba_pkg::*;

	localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
	localparam int LIMIT       = 400000;
	localparam int RAND_ITEMS  = 2000;
	localparam int PHASE_ITEMS = 100;
	// Pause after the last result has left, which covers any load still
	// being written.
	localparam int SETTLE      = NUM_BLOCKS + 8;

	// fit_mode has a fourth code that selects no policy at all.
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	typedef enum bit {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} alloc_op_e;

	// One result: whether a block was granted and which one.
	typedef struct packed {
		logic                granted;
		logic [CHOSEN_W-1:0] block;
	} grant_t;

	// ------------------------------------------------------------------------
	// Scoreboard: a shadow of the block table, the two registers and the
	// grants still awaited from the block.
	// ------------------------------------------------------------------------
	class alloc_table_model;
		logic [AMOUNT_W-1:0] capacity [NUM_BLOCKS];
		bit                  taken [NUM_BLOCKS];
		logic [MODE_W-1:0]   mode;
		logic [COUNT_W-1:0]  count;
		grant_t              expected_grants [$];
		int                  mismatches;
		int                  loads;
		int                  requests;
		int                  grants_seen;
		int                  refusals_seen;

		function new();
			mode = MODE_RESET;
			count = COUNT_RESET;
			foreach (taken[k]) begin
				taken[k] = 1'b0;
				capacity[k] = '0;
			end
			mismatches = 0;
			loads = 0;
			requests = 0;
			grants_seen = 0;
			refusals_seen = 0;
		endfunction

		function void write_reg(logic sel, logic [31:0] value);
			if (sel == REG_FIT_MODE) begin
				mode = value[MODE_W-1:0];
			end else begin
				count = value[COUNT_W-1:0];
			end
		endfunction

		// Runs the selected policy over the blocks in use and updates the
		// table exactly as the block should.
		function grant_t search_table(logic [AMOUNT_W-1:0] amount);
			grant_t g;
			int     n;
			int     pick;
			bit     have;
			g = '0;
			have = 1'b0;
			pick = 0;
			n = (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
			case (mode)
				MODE_FIRST: begin
					for (int j = 0; j < n; j++) begin
						if (!taken[j] && capacity[j] >= amount) begin
							have = 1'b1;
							pick = j;
							break;
						end
					end
					if (have) begin
						taken[pick] = 1'b1;
						g.granted = 1'b1;
					end
				end
				MODE_BEST: begin
					// Taken marks play no part here; the capacity shrinks instead.
					for (int j = 0; j < n; j++) begin
						if (capacity[j] >= amount && (!have || capacity[j] < capacity[pick])) begin
							have = 1'b1;
							pick = j;
						end
					end
					if (have) begin
						capacity[pick] = capacity[pick] - amount;
						g.granted = 1'b1;
					end
				end
				MODE_WORST: begin
					// Largest free block first, then the size test on that block alone.
					for (int j = 0; j < n; j++) begin
						if (!taken[j] && (!have || capacity[j] > capacity[pick])) begin
							have = 1'b1;
							pick = j;
						end
					end
					if (have && capacity[pick] >= amount) begin
						taken[pick] = 1'b1;
						g.granted = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (g.granted) begin
				g.block = pick[CHOSEN_W-1:0];
			end
			return g;
		endfunction

		function void note_item(alloc_op_e op, logic [LOAD_IDX_W-1:0] idx,
				logic [AMOUNT_W-1:0] amount);
			if (op == OP_LOAD) begin
				loads++;
				if (idx < NUM_BLOCKS) begin
					capacity[idx] = amount;
					taken[idx] = 1'b0;
				end
			end else begin
				requests++;
				expected_grants.push_back(search_table(amount));
			end
		endfunction

		task report(string what);
			if (mismatches < 30) begin
				$display("[%0t] mismatch: %s", $realtime, what);
			end
			mismatches++;
		endtask

		task check_result(logic granted, logic [CHOSEN_W-1:0] block);
			grant_t want;
			if (granted) begin
				grants_seen++;
			end else begin
				refusals_seen++;
			end
			if (expected_grants.size() == 0) begin
				report($sformatf("result granted=%0b block=%0d with none awaited",
					granted, block));
			end else begin
				want = expected_grants.pop_front();
				if (granted !== want.granted) begin
					report($sformatf("granted %0b, wanted %0b", granted, want.granted));
				end
				if (block !== want.block) begin
					report($sformatf("chosen_block %0d, wanted %0d", block, want.block));
				end
			end
		endtask

		task check_leftovers();
			if (expected_grants.size() != 0) begin
				report($sformatf("%0d results never arrived", expected_grants.size()));
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Signals and the block itself
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [23:0]         s_tdata;  // [3:0] load_index, [19:4] amount
	logic                s_tuser;  // [0] op
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;  // [3:0] chosen_block
	logic                m_tuser;  // [0] granted
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	alloc_table_model model;
	bit               calm;      // when set, neither side idles
	int               cycles;
	int               settings;

	fit_policy_block_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 4 ns clock: two ns high, two ns low.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog. A correct run needs well under a tenth of this limit, even
	// with every request waiting out the longest receiver stall.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: drops m_tready with a chance of about 18 percent unless the
	// current phase is a calm one. Changes land on the falling edge.
	always @(negedge clk) begin
		m_tready = (!calm && $urandom_range(99) < 18) ? 1'b0 : 1'b1;
	end

	// Every result accepted at a rising edge goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			model.check_result(m_tuser, m_tdata[CHOSEN_W-1:0]);
		end
	end

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// Presents one item and waits for the block to take it. s_tvalid stays
	// high afterwards; the next call or drain() sets it anew.
	task automatic send_item(input alloc_op_e op, input logic [LOAD_IDX_W-1:0] idx,
			input logic [AMOUNT_W-1:0] amount);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 18) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {4'b0000, amount, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model.note_item(op, idx, amount);
	endtask

	// Stops the sender and waits until every awaited result has come back,
	// then lets the block settle. Used before each policy setting and at the end.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (model.expected_grants.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then an access cycle ending at the rising edge
	// where the register takes the value.
	task automatic write_reg(input logic sel, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {sel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		model.write_reg(sel, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
		drain();
		write_reg(REG_FIT_MODE, 32'(mode));
		write_reg(REG_BLOCK_COUNT, 32'(count));
		settings++;
	endtask

	// Request sizes lean towards the interesting edges: zero, full scale,
	// and values at or just around a capacity currently in the table.
	function automatic logic [AMOUNT_W-1:0] pick_request_size();
		logic [AMOUNT_W-1:0] c;
		c = model.capacity[$urandom_range(0, NUM_BLOCKS - 1)];
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return AMOUNT_W'($urandom_range(0, 65535));
			4, 5: return AMOUNT_W'($urandom_range(0, 255));
			6, 7: return c;
			8: return c + 1'b1;
			default: return c - 1'b1;
		endcase
	endfunction

	function automatic logic [AMOUNT_W-1:0] pick_capacity();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return AMOUNT_W'($urandom_range(0, 511));
			default: return AMOUNT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		case ($urandom_range(11))
			0: return MODE_NONE;
			1, 2, 3, 4: return MODE_FIRST;
			5, 6, 7: return MODE_BEST;
			default: return MODE_WORST;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return COUNT_W'(0);
			1: return COUNT_W'(1);
			2, 3: return COUNT_W'(NUM_BLOCKS);
			4: return COUNT_W'($urandom_range(NUM_BLOCKS + 1, 31));
			default: return COUNT_W'($urandom_range(1, NUM_BLOCKS));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	logic [AMOUNT_W-1:0] seed_caps [NUM_BLOCKS] = '{
		16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'd100, 16'hFFFE, 16'd5,
		16'd5, 16'd300, 16'h5555, 16'hAAAA, 16'd2, 16'd1000, 16'hFFFF, 16'd50
	};

	initial begin
		int sent;
		model    = new();
		calm     = 1'b0;
		cycles   = 0;
		settings = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Every block is loaded first, so no search can ever
		// touch a capacity that has not been written.
		for (int k = 0; k < NUM_BLOCKS; k++) begin
			send_item(OP_LOAD, LOAD_IDX_W'(k), seed_caps[k]);
		end
		// First fit under the reset settings: zero size, full-scale sizes
		// until the largest blocks are all taken and the last one is refused.
		send_item(OP_REQUEST, 4'hF, 16'h0000);
		send_item(OP_REQUEST, 4'h0, 16'hFFFF);
		send_item(OP_REQUEST, 4'h0, 16'hFFFF);
		send_item(OP_REQUEST, 4'h0, 16'hFFFF);
		// Best fit: a tie between two equal blocks, then a taken block that is
		// still eligible because best fit ignores taken marks.
		set_policy(MODE_BEST, COUNT_W'(NUM_BLOCKS));
		send_item(OP_REQUEST, 4'h0, 16'd3);
		send_item(OP_REQUEST, 4'h0, 16'hFFFF);
		// Worst fit: the largest free block takes a small request; then the
		// largest free block turns out to be too small.
		set_policy(MODE_WORST, COUNT_W'(NUM_BLOCKS));
		send_item(OP_REQUEST, 4'h0, 16'd1);
		send_item(OP_REQUEST, 4'h0, 16'hFFFF);
		// The unused policy code and an empty table both refuse everything.
		set_policy(MODE_NONE, COUNT_W'(NUM_BLOCKS));
		send_item(OP_REQUEST, 4'h0, 16'h0000);
		set_policy(MODE_FIRST, COUNT_W'(0));
		send_item(OP_REQUEST, 4'h0, 16'h0000);

		// Random part, in phases of one setting each. Roughly half the items
		// are loads, which keeps freeing blocks so that first and worst fit
		// keep finding candidates. Every fifth phase runs with no idling.
		sent = 0;
		for (int phase = 0; sent < RAND_ITEMS; phase++) begin
			set_policy(pick_mode(), pick_count());
			calm = (phase % 5 == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 45) begin
					send_item(OP_LOAD, LOAD_IDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
						pick_capacity());
				end else begin
					send_item(OP_REQUEST, LOAD_IDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
						pick_request_size());
				end
				sent++;
			end
		end
		calm = 1'b0;
		// The extreme settings once more, right at the end.
		set_policy(MODE_WORST, COUNT_W'(31));
		for (int i = 0; i < 8; i++) begin
			send_item(OP_REQUEST, 4'h0, pick_request_size());
		end
		set_policy(MODE_BEST, COUNT_W'(1));
		for (int i = 0; i < 8; i++) begin
			send_item(OP_REQUEST, 4'h0, pick_request_size());
		end

		// Wind down: nothing more is sent, every result must come back, and
		// any stray result in the tail is still caught by the scoreboard.
		drain();
		model.check_leftovers();

		$display("Covered %0d loads and %0d requests over %0d register settings.",
			model.loads, model.requests, settings);
		$display("Results seen: %0d granted, %0d refused; %0d mismatches.",
			model.grants_seen, model.refusals_seen, model.mismatches);
		if (model.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
